// ===== src/strk_pkg.sv =====
// strk_pkg: shared types and codes for the score table ranker
// holds request and status codes, field widths and the point increment
// no dependencies
package strk_pkg;

  localparam int REQ_TYPE_W = 2;
  localparam int MEMBER_W   = 7;
  localparam int STATUS_W   = 2;
  localparam int RANK_W     = 7;
  localparam int SCORE_W    = 16;

  localparam int ADD_POINTS = 10;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_RANK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_MEMBER = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

endpackage

// ===== src/strk_req_if.sv =====
// strk_req_if: request channel of the score table ranker
// valid/ready handshake with request type and member number; uses strk_pkg
interface strk_req_if;
  logic                            valid;
  logic                            ready;
  logic [strk_pkg::REQ_TYPE_W-1:0] req_type;
  logic [strk_pkg::MEMBER_W-1:0]   member_number;

  modport source (output valid, req_type, member_number, input ready);
  modport sink   (input valid, req_type, member_number, output ready);
endinterface

// ===== src/strk_res_if.sv =====
// strk_res_if: result channel of the score table ranker
// valid/ready handshake with status, rank, member, score and last; uses strk_pkg
interface strk_res_if;
  logic                          valid;
  logic                          ready;
  logic [strk_pkg::STATUS_W-1:0] status;
  logic [strk_pkg::RANK_W-1:0]   rank;
  logic [strk_pkg::MEMBER_W-1:0] ranked_member;
  logic [strk_pkg::SCORE_W-1:0]  score;
  logic                          last;

  modport source (output valid, status, rank, ranked_member, score, last, input ready);
  modport sink   (input valid, status, rank, ranked_member, score, last, output ready);
endinterface

// ===== src/strk_ram.sv =====
// strk_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module strk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/score_table_ranker.sv =====
// score_table_ranker: member score table with insert, add and ranked readout
// depends on strk_pkg, strk_req_if, strk_res_if and strk_ram
//
// usage
//   req channel (sink): one transfer carries req_type and member_number.
//     insert appends a member at zero points, add raises a member by ten
//     points (saturating), rank reads the whole table out best first.
//   res channel (source): status, rank, ranked_member, score and last.
//     insert and add give one result; rank gives one result per member,
//     ties going to the higher member number, last set on the final one.
//     request type three is taken and gives no result.
// timing
//   req.ready is high only while the sequencer is idle.
//   insert and errors: decided and held as the pending result, then loaded.
//   add: saturating add and write back, then the result is loaded.
//   rank of n members: each rank is one full pass of the shared compare
//     unit over the score ram, one entry per cycle, then a drain state for
//     the ram read latency and an emit state that hands off the result.
// stalls and reset
//   the result register holds a result while res.ready is low; the
//   sequencer waits before loading the next one, so nothing is lost.
//   rst empties the table and drops any pending result; the score ram
//   needs no clearing because only inserted entries are ever read.
module score_table_ranker #(
  parameter int MAX_MEMBERS = 64,
  parameter int SCORE_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  strk_req_if.sink   req,
  strk_res_if.source res
);

  localparam int IDX_W = $clog2(MAX_MEMBERS);
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ADD    = 6'b000010,
    S_RESULT = 6'b000100,
    S_SCAN   = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] member_count;

  // score ram ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [SCORE_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [SCORE_BITS-1:0] ram_rdata;

  // add path
  logic [IDX_W-1:0]              add_idx;
  logic [strk_pkg::MEMBER_W-1:0] add_member;
  logic [SCORE_BITS:0]           add_sum;
  logic [SCORE_BITS-1:0]         add_score;
  logic                          add_bad;
  logic [IDX_W-1:0]              req_idx;

  // pending single result for insert, add and errors
  strk_pkg::status_t             pend_status;
  logic [strk_pkg::MEMBER_W-1:0] pend_member;
  logic [strk_pkg::SCORE_W-1:0]  pend_score;

  // ranking scan: the next pick is the largest (score, index) pair below
  // the previous pick, which stands in for per-member taken marks
  logic [CNT_W-1:0]      scan_i;
  logic [CNT_W-1:0]      rank_k;
  logic                  cmp_v;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  best_v;
  logic [SCORE_BITS-1:0] best_s;
  logic [IDX_W-1:0]      best_i;
  logic                  bound_v;
  logic [SCORE_BITS-1:0] bound_s;
  logic [IDX_W-1:0]      bound_i;
  logic                  eligible;
  logic                  take;
  logic                  rank_last;

  // result register
  logic out_v;
  logic slot_free;

  logic accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign slot_free = !out_v || res.ready;
  assign res.valid = out_v;

  // member number checks for add
  assign add_bad = (req.member_number == '0) ||
                   (32'(req.member_number) > 32'(member_count));
  assign req_idx = IDX_W'(32'(req.member_number) - 32'd1);

  // saturating add, max is all ones so the carry flags overflow
  assign add_sum   = {1'b0, ram_rdata} + (SCORE_BITS + 1)'(strk_pkg::ADD_POINTS);
  assign add_score = add_sum[SCORE_BITS] ? '1 : add_sum[SCORE_BITS-1:0];

  // shared compare unit
  assign eligible = !bound_v || (ram_rdata < bound_s) ||
                    ((ram_rdata == bound_s) && (cmp_idx < bound_i));
  assign take     = cmp_v && eligible && (!best_v || ram_rdata >= best_s);

  assign rank_last = (32'(rank_k) + 32'd1 == 32'(member_count));

  // ram port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = member_count[IDX_W-1:0];
    ram_wdata = '0;
    ram_raddr = scan_i[IDX_W-1:0];
    if (state == S_IDLE) begin
      ram_raddr = req_idx;
      if (accept && req.req_type == strk_pkg::REQ_INSERT &&
          32'(member_count) < 32'(MAX_MEMBERS)) begin
        ram_we = 1'b1;
      end
    end else if (state == S_ADD) begin
      ram_we    = 1'b1;
      ram_waddr = add_idx;
      ram_wdata = add_score;
    end
  end

  strk_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (MAX_MEMBERS)
  ) u_scores (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            strk_pkg::REQ_INSERT: state_next = S_RESULT;
            strk_pkg::REQ_ADD:    state_next = add_bad ? S_RESULT : S_ADD;
            strk_pkg::REQ_RANK:   state_next = (member_count == '0) ? S_RESULT : S_SCAN;
            default:              state_next = S_IDLE;
          endcase
        end
      end
      S_ADD:    state_next = S_RESULT;
      S_RESULT: if (slot_free) state_next = S_IDLE;
      S_SCAN: begin
        if (32'(scan_i) + 32'd1 == 32'(member_count)) state_next = S_DRAIN;
      end
      S_DRAIN:  state_next = S_EMIT;
      S_EMIT: begin
        if (slot_free) state_next = rank_last ? S_IDLE : S_SCAN;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      member_count <= '0;
      out_v        <= 1'b0;
      cmp_v        <= 1'b0;
    end else begin
      state <= state_next;
      cmp_v <= (state == S_SCAN);
      // a free slot either takes a new result or empties
      if (slot_free) out_v <= (state == S_RESULT) || (state == S_EMIT);

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_score <= '0;
            case (req.req_type)
              strk_pkg::REQ_INSERT: begin
                if (32'(member_count) < 32'(MAX_MEMBERS)) begin
                  member_count <= member_count + CNT_W'(1);
                  pend_status  <= strk_pkg::ST_OK;
                  pend_member  <= strk_pkg::MEMBER_W'(32'(member_count) + 32'd1);
                end else begin
                  pend_status <= strk_pkg::ST_FULL;
                  pend_member <= '0;
                end
              end
              strk_pkg::REQ_ADD: begin
                pend_status <= add_bad ? strk_pkg::ST_BAD_MEMBER : strk_pkg::ST_OK;
                pend_member <= '0;
                add_idx     <= req_idx;
                add_member  <= req.member_number;
              end
              strk_pkg::REQ_RANK: begin
                pend_status <= strk_pkg::ST_EMPTY;
                pend_member <= '0;
                scan_i      <= '0;
                rank_k      <= '0;
                best_v      <= 1'b0;
                bound_v     <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_ADD: begin
          pend_member <= add_member;
          pend_score  <= strk_pkg::SCORE_W'(32'(add_score));
        end
        S_RESULT: begin
          if (slot_free) begin
            res.status        <= pend_status;
            res.rank          <= '0;
            res.ranked_member <= pend_member;
            res.score         <= pend_score;
            res.last          <= 1'b1;
          end
        end
        S_SCAN: begin
          cmp_idx <= scan_i[IDX_W-1:0];
          scan_i  <= scan_i + CNT_W'(1);
        end
        S_DRAIN: ;
        S_EMIT: begin
          if (slot_free) begin
            res.status        <= strk_pkg::ST_OK;
            res.rank          <= strk_pkg::RANK_W'(32'(rank_k) + 32'd1);
            res.ranked_member <= strk_pkg::MEMBER_W'(32'(best_i) + 32'd1);
            res.score         <= strk_pkg::SCORE_W'(32'(best_s));
            res.last          <= rank_last;
            bound_v           <= 1'b1;
            bound_s           <= best_s;
            bound_i           <= best_i;
            rank_k            <= rank_k + CNT_W'(1);
            scan_i            <= '0;
            best_v            <= 1'b0;
          end
        end
        default: ;
      endcase

      // compare of each ram read lands in the cycle after the read address
      if (take) begin
        best_v <= 1'b1;
        best_s <= ram_rdata;
        best_i <= cmp_idx;
      end
    end
  end

endmodule
